// ===== design/bur_pkg.sv =====
// Shared types and constants for the bitmap row-run unpacker.
// Used by bur_front, bur_queue, bur_back and bitmap_unpack_row_runs_top.
package bur_pkg;

  localparam int CoordW     = 7;
  localparam int PixCountW  = 14;
  localparam int NBitsW     = 4;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic STATUS_RUN = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COLS,
    PH_PIXELS
  } phase_e;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [CoordW-1:0] run_row;
    logic [CoordW-1:0] run_col;
    logic [CoordW-1:0] run_length;
    logic              mode;
    logic              last;
  } out_t;

  // one queued job: a pixel byte or an invalid-size report
  typedef struct packed {
    logic              is_error;
    logic              new_frame;
    logic              mode;
    logic [NBitsW-1:0] nbits;
    logic [7:0]        data;
    logic [CoordW-1:0] cols;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
  } entry_t;

endpackage

// ===== design/bur_front.sv =====
// Front end: parses the header bytes, counts pixels and queues pixel bytes.
// Depends on bur_pkg.
module bur_front #(
  parameter int CANVAS_SIZE = 100
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bur_pkg::in_t    in_i,
  input  logic            full_i,
  output logic            push_o,
  output bur_pkg::entry_t entry_o
);

  localparam logic [bur_pkg::CoordW-1:0] Canvas = bur_pkg::CoordW'(CANVAS_SIZE);

  bur_pkg::phase_e phase_q, phase_d;
  logic [bur_pkg::CoordW-1:0]    rows_q, rows_d, cols_q, cols_d;
  logic [bur_pkg::CoordW-1:0]    top_q, top_d, left_q, left_d;
  logic                          mode_q, mode_d, first_q, first_d;
  logic [bur_pkg::PixCountW-1:0] left_px_q, left_px_d;
  logic [bur_pkg::NBitsW-1:0]    nbits;
  logic                          accept;
  logic [bur_pkg::CoordW-1:0]    byte_lo;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign byte_lo    = in_i.data_byte[bur_pkg::CoordW-1:0];
  assign nbits      = (left_px_q >= bur_pkg::PixCountW'(8)) ? bur_pkg::NBitsW'(8)
                                                           : left_px_q[bur_pkg::NBitsW-1:0];

  always_comb begin
    phase_d   = phase_q;
    rows_d    = rows_q;
    cols_d    = cols_q;
    top_d     = top_q;
    left_d    = left_q;
    mode_d    = mode_q;
    first_d   = first_q;
    left_px_d = left_px_q;
    push_o    = 1'b0;
    entry_o   = '0;
    entry_o.mode = mode_q;
    if (accept) begin
      if (in_i.frame_start) begin
        // rows = byte - 128 above 128, and 128 itself wraps to zero
        mode_d  = in_i.data_byte[7] && (byte_lo != '0);
        rows_d  = byte_lo;
        phase_d = bur_pkg::PH_COLS;
      end else begin
        case (phase_q)
          bur_pkg::PH_COLS: begin
            cols_d = byte_lo;
            if (rows_q == '0 || in_i.data_byte == 8'd0 || rows_q > Canvas ||
                in_i.data_byte > {1'b0, Canvas}) begin
              push_o           = 1'b1;
              entry_o.is_error = 1'b1;
              phase_d          = bur_pkg::PH_IDLE;
            end else begin
              left_px_d = bur_pkg::PixCountW'(rows_q) * bur_pkg::PixCountW'(byte_lo);
              top_d     = bur_pkg::CoordW'((Canvas - rows_q) >> 1);
              left_d    = bur_pkg::CoordW'((Canvas - byte_lo) >> 1);
              first_d   = 1'b1;
              phase_d   = bur_pkg::PH_PIXELS;
            end
          end
          bur_pkg::PH_PIXELS: begin
            push_o            = 1'b1;
            entry_o.new_frame = first_q;
            entry_o.nbits     = nbits;
            entry_o.data      = in_i.data_byte;
            entry_o.cols      = cols_q;
            entry_o.top       = top_q;
            entry_o.left      = left_q;
            first_d           = 1'b0;
            left_px_d         = left_px_q - bur_pkg::PixCountW'(nbits);
            if (left_px_q <= bur_pkg::PixCountW'(8)) begin
              phase_d = bur_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bur_pkg::PH_IDLE;
      rows_q    <= '0;
      cols_q    <= '0;
      mode_q    <= 1'b0;
      first_q   <= 1'b0;
      left_px_q <= '0;
    end else begin
      phase_q   <= phase_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      mode_q    <= mode_d;
      first_q   <= first_d;
      left_px_q <= left_px_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    left_q <= left_d;
  end

endmodule

// ===== design/bur_queue.sv =====
// Short queue of jobs between the front end and the run extractor.
// Depends on bur_pkg.
module bur_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bur_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output bur_pkg::entry_t entry_o
);

  bur_pkg::entry_t mem_q [bur_pkg::QueueDepth];
  logic [bur_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [bur_pkg::QueuePtrW:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (bur_pkg::QueuePtrW+1)'(bur_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (bur_pkg::QueuePtrW+1)'(do_push)
                     - (bur_pkg::QueuePtrW+1)'(do_pop);
    end
  end

endmodule

// ===== design/bur_back.sv =====
// Back end: walks queued pixel bytes one pixel a cycle unless stalled and emits
// row runs. A result is held in a register so its last flag is known before it
// leaves. Depends on bur_pkg.
module bur_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  bur_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bur_pkg::out_t   out_o
);

  logic [2:0]                 bit_q;
  logic [bur_pkg::CoordW-1:0] col_q, row_q, begin_q;
  logic                       open_q;
  bur_pkg::out_t              hold_q, out_q;
  logic                       hold_valid_q, out_valid_q;

  logic                       fresh, px, row_end, emit, is_last, step, out_free, move;
  logic [bur_pkg::CoordW-1:0] col, row, begin_eff, run_start;
  logic                       open;
  bur_pkg::out_t              res;

  always_comb begin
    fresh     = entry_i.new_frame && (bit_q == 3'd0);
    col       = fresh ? '0 : col_q;
    row       = fresh ? '0 : row_q;
    open      = fresh ? 1'b0 : open_q;
    px        = entry_i.data[3'd7 - bit_q];
    row_end   = ({1'b0, col} + 8'd1) >= {1'b0, entry_i.cols};
    begin_eff = open ? begin_q : col;
    run_start = px ? begin_eff : begin_q;
    is_last   = entry_i.is_error ||
                ({1'b0, bit_q} == (entry_i.nbits - bur_pkg::NBitsW'(1)));
    emit      = entry_i.is_error || (px ? row_end : open);

    res        = '0;
    res.mode   = entry_i.mode;
    res.last   = is_last;
    if (entry_i.is_error) begin
      res.status = bur_pkg::STATUS_ERR;
    end else begin
      res.status     = bur_pkg::STATUS_RUN;
      res.run_row    = entry_i.top + row;
      res.run_col    = entry_i.left + run_start;
      res.run_length = px ? (col - begin_eff + 1'b1) : (col - begin_q);
    end

    out_free = !out_valid_q || out_ready_i;
    step     = valid_i && (!emit || !hold_valid_q || out_free);
    // the held result leaves once it is known to be final or a newer one follows
    move     = hold_valid_q && out_free && (hold_q.last || (step && emit));
    pop_o    = step && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      begin_q      <= '0;
      open_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (step) begin
        bit_q <= is_last ? 3'd0 : bit_q + 3'd1;
        if (!entry_i.is_error) begin
          open_q  <= px && !row_end;
          begin_q <= (px && !open) ? col : begin_q;
          col_q   <= row_end ? '0 : col + 1'b1;
          row_q   <= row_end ? row + 1'b1 : row;
        end
      end
      if (step && emit) begin
        hold_valid_q <= 1'b1;
      end else if (move) begin
        hold_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      hold_q <= res;
    end else if (step && is_last) begin
      hold_q.last <= 1'b1;
    end
    if (move) begin
      out_q <= hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== design/bitmap_unpack_row_runs_top.sv =====
// Bitmap row-run unpacker top level: front end, job queue and run extractor.
// Depends on bur_pkg, bur_front, bur_queue and bur_back.
//
// Each frame is a mode/rows byte flagged by frame_start, a column byte and
// packed pixel bytes; the block returns one request per horizontal run of set
// pixels in canvas coordinates, or one error request for a bad size. The run
// extractor walks pixel bytes one pixel a cycle while its output is not
// blocked; a four-deep queue lets bytes be taken while earlier ones are still
// being walked, and an output register lets the walk go on while a result
// waits. A run is emitted on the pixel that closes it and last marks the
// final request caused by a byte.
module bitmap_unpack_row_runs_top #(
  parameter int CANVAS_SIZE = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bur_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bur_pkg::out_t out_o
);

  logic            push, full, q_valid, pop;
  bur_pkg::entry_t push_entry, head_entry;

  bur_front #(.CANVAS_SIZE(CANVAS_SIZE)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  bur_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  bur_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("job pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == bur_pkg::STATUS_ERR) |->
      (out_o.last && out_o.run_length == '0))
    else $error("error request malformed");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == bur_pkg::STATUS_RUN) |-> (out_o.run_length != '0))
    else $error("run request with zero length");

endmodule

// ===== tb/bitmap_unpack_row_runs_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for bitmap_unpack_row_runs_top: framed image bytes in, row runs out.
// Depends on bur_pkg and the RTL; a run tracker class predicts every request.
module bitmap_unpack_row_runs_top_tb;

  localparam int CanvasSize    = 100;
  localparam int DirectedItems = 25;
  localparam int RandomItems   = 195;
  localparam int HoldAfter     = 30;    // results seen before the long hold-off
  localparam int HoldCycles    = 400;
  localparam int IdleLimit     = 3000;  // cycles with no handshake at all
  localparam int DrainCycles   = 100;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  bur_pkg::in_t  in_item   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  bur_pkg::out_t out_o;

  bit fast_send;
  bit fast_recv;
  int bytes_sent;
  int frames_sent;
  int frames_bad;
  int results_seen;
  int errors_seen;
  int idle_cycles;

  // Predicts the run requests of the block and checks what comes out.
  class run_tracker;
    bur_pkg::out_t   expected_runs[$];
    int              mismatches;
    int              checked;
    bur_pkg::phase_e ph;
    logic [6:0]      img_rows;
    logic [6:0]      img_cols;
    logic [6:0]      row_pos;
    logic [6:0]      col_pos;
    logic [6:0]      run_begin;
    logic            hdr_mode;
    logic            run_open;
    logic [13:0]     pixels_left;

    function new();
      mismatches  = 0;
      checked     = 0;
      ph          = bur_pkg::PH_IDLE;
      img_rows    = '0;
      img_cols    = '0;
      row_pos     = '0;
      col_pos     = '0;
      run_begin   = '0;
      hdr_mode    = 1'b0;
      run_open    = 1'b0;
      pixels_left = '0;
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    function bur_pkg::out_t make_run(int len);
      bur_pkg::out_t r;
      int            top;
      int            left;
      top          = (CanvasSize - int'(img_rows)) / 2;
      left         = (CanvasSize - int'(img_cols)) / 2;
      r            = '0;
      r.status     = bur_pkg::STATUS_RUN;
      r.run_row    = 7'(top + int'(row_pos));
      r.run_col    = 7'(left + int'(run_begin));
      r.run_length = 7'(len);
      r.mode       = hdr_mode;
      return r;
    endfunction

    function void take_byte(bur_pkg::in_t item);
      bur_pkg::out_t fresh[$];
      bur_pkg::out_t r;
      logic          px;
      bit            row_end;
      if (item.frame_start) begin
        // new header; an open run is dropped silently
        if (item.data_byte > 8'd128) begin
          hdr_mode = 1'b1;
          img_rows = 7'(item.data_byte - 8'd128);
        end else begin
          hdr_mode = 1'b0;
          img_rows = item.data_byte[6:0];  // 128 wraps to zero rows
        end
        run_open = 1'b0;
        ph       = bur_pkg::PH_COLS;
        return;
      end
      case (ph)
        bur_pkg::PH_COLS: begin
          img_cols = item.data_byte[6:0];
          if (img_rows == 0 || item.data_byte == 0 || int'(img_rows) > CanvasSize ||
              int'(item.data_byte) > CanvasSize) begin
            r        = '0;
            r.status = bur_pkg::STATUS_ERR;
            r.mode   = hdr_mode;
            r.last   = 1'b1;
            expected_runs.push_back(r);
            ph = bur_pkg::PH_IDLE;
          end else begin
            row_pos     = '0;
            col_pos     = '0;
            run_open    = 1'b0;
            run_begin   = '0;
            pixels_left = 14'(int'(img_rows) * int'(img_cols));
            ph          = bur_pkg::PH_PIXELS;
          end
        end
        bur_pkg::PH_PIXELS: begin
          for (int b = 7; b >= 0 && pixels_left != 0; b--) begin
            px      = item.data_byte[b];
            row_end = int'(col_pos) + 1 >= int'(img_cols);
            if (px) begin
              if (!run_open) begin
                run_open  = 1'b1;
                run_begin = col_pos;
              end
              if (row_end) begin
                fresh.push_back(make_run(int'(col_pos) - int'(run_begin) + 1));
                run_open = 1'b0;
              end
            end else if (run_open) begin
              fresh.push_back(make_run(int'(col_pos) - int'(run_begin)));
              run_open = 1'b0;
            end
            if (row_end) begin
              col_pos = '0;
              row_pos = row_pos + 7'd1;
            end else begin
              col_pos = col_pos + 7'd1;
            end
            pixels_left = pixels_left - 14'd1;
          end
          // padding bits of the final byte are dropped
          if (pixels_left == 0) begin
            run_open = 1'b0;
            ph       = bur_pkg::PH_IDLE;
          end
          if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
          foreach (fresh[i]) expected_runs.push_back(fresh[i]);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH request %0d: %s", $realtime, checked, msg);
      mismatches++;
    endtask

    task check_run(bur_pkg::out_t got);
      bur_pkg::out_t want;
      checked++;
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected, status %0d row %0d col %0d len %0d",
                                  got.status, got.run_row, got.run_col, got.run_length));
        return;
      end
      want = expected_runs.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.run_row !== want.run_row)
        report_mismatch($sformatf("run_row got %0d want %0d", got.run_row, want.run_row));
      if (got.run_col !== want.run_col)
        report_mismatch($sformatf("run_col got %0d want %0d", got.run_col, want.run_col));
      if (got.run_length !== want.run_length)
        report_mismatch($sformatf("run_length got %0d want %0d", got.run_length,
                                  want.run_length));
      if (got.mode !== want.mode)
        report_mismatch($sformatf("mode got %0d want %0d", got.mode, want.mode));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  run_tracker tracker = new();

  bitmap_unpack_row_runs_top #(
    .CANVAS_SIZE(CanvasSize)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_i       (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no handshake for %0d cycles", IdleLimit);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // valid stays high across back-to-back bytes; only lowered for a gap
  task automatic send_byte(input logic fs, input logic [7:0] b, input bit counted);
    bur_pkg::in_t item;
    int           gap;
    item.frame_start = fs;
    item.data_byte   = b;
    gap = fast_send ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(item);
    if (counted) bytes_sent++;
  endtask

  function automatic logic [7:0] pixel_byte(int style);
    case (style)
      0:       return 8'($urandom);
      1:       return 8'($urandom | $urandom);
      2:       return 8'($urandom & $urandom & $urandom);
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] header_byte(logic m, int rows);
    return m ? 8'(128 + rows) : 8'(rows);
  endfunction

  // header, column byte and the first npix_bytes pixel bytes
  task automatic send_frame(input logic m, input int rows, input int cols,
                            input int npix_bytes, input int style);
    send_byte(1'b1, header_byte(m, rows), 1'b1);
    send_byte(1'b0, 8'(cols), 1'b1);
    for (int i = 0; i < npix_bytes; i++) send_byte(1'b0, pixel_byte(style), 1'b1);
    frames_sent++;
  endtask

  task automatic send_bad_size();
    logic [7:0] hdr;
    logic [7:0] cb;
    case ($urandom_range(0, 3))
      0: begin
        hdr = 8'(128 * $urandom_range(0, 1));  // zero rows
        cb  = 8'($urandom);
      end
      1: begin
        hdr = 8'($urandom_range(CanvasSize + 1, 127) + 128 * $urandom_range(0, 1));
        cb  = 8'($urandom);
      end
      2: begin
        hdr = header_byte($urandom_range(0, 1), $urandom_range(1, CanvasSize));
        cb  = 8'd0;
      end
      default: begin
        hdr = header_byte($urandom_range(0, 1), $urandom_range(1, CanvasSize));
        cb  = 8'($urandom_range(CanvasSize + 1, 255));
      end
    endcase
    send_byte(1'b1, hdr, 1'b1);
    send_byte(1'b0, cb, 1'b1);
    frames_sent++;
    frames_bad++;
  endtask

  initial begin : receiver
    int stall;
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HoldAfter) begin
        // long hold-off so the queue fills and the input stalls
        held  = 1'b1;
        stall = HoldCycles;
      end else if (fast_recv) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_run(out_o);
      results_seen++;
      if (out_o.status == bur_pkg::STATUS_ERR) errors_seen++;
      if ($urandom_range(0, 15) == 0) fast_recv = !fast_recv;
    end
  end

  initial begin : stimulus
    int  kind;
    int  rows;
    int  cols;
    int  nbytes;
    bit  ended_idle;
    logic m;
    ended_idle = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle byte, bad sizes, restart with an open run, full-width row
    send_byte(1'b0, 8'hA5, 1'b1);
    send_byte(1'b1, 8'd128, 1'b1);
    send_byte(1'b0, 8'd5, 1'b1);
    send_byte(1'b1, 8'd129, 1'b1);
    send_byte(1'b0, 8'd0, 1'b1);
    send_byte(1'b1, 8'd1, 1'b1);
    send_byte(1'b0, 8'd255, 1'b1);
    send_byte(1'b1, 8'd3, 1'b1);
    send_byte(1'b0, 8'd3, 1'b1);
    send_byte(1'b0, 8'hFF, 1'b1);
    frames_sent += 4;
    frames_bad  += 4;
    send_frame(1'b1, 1, CanvasSize, 13, 3);

    while (bytes_sent < DirectedItems + RandomItems) begin
      if ($urandom_range(0, 3) == 0) fast_send = !fast_send;
      kind = $urandom_range(0, 19);
      m    = $urandom_range(0, 1);
      rows = $urandom_range(1, 12);
      cols = $urandom_range(1, 12);
      if (kind < 2) begin
        send_bad_size();
        ended_idle = 1'b1;
      end else if (kind < 4) begin
        // broken frame: cut short, the next header restarts
        nbytes = (rows * cols + 7) / 8;
        if ($urandom_range(0, 2) == 0) begin
          send_byte(1'b1, header_byte(m, rows), 1'b1);
          frames_sent++;
        end else begin
          send_frame(m, rows, cols, $urandom_range(0, nbytes - 1), $urandom_range(0, 3));
        end
        frames_bad++;
        ended_idle = 1'b0;
      end else begin
        if (kind == 4) begin
          if ($urandom_range(0, 1) == 0) begin
            rows = CanvasSize;
            cols = $urandom_range(1, 2);
          end else begin
            rows = $urandom_range(1, 2);
            cols = CanvasSize;
          end
        end
        nbytes = (rows * cols + 7) / 8;
        send_frame(m, rows, cols, nbytes, $urandom_range(0, 3));
        ended_idle = 1'b1;
      end
      if (ended_idle && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) send_byte(1'b0, 8'($urandom), 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d expected requests never came", tracker.pending()));

    $display("Sent %0d bytes in %0d frames, %0d of them cut short or badly sized.",
             bytes_sent, frames_sent, frames_bad);
    $display("Checked %0d requests, %0d size errors; %0d mismatches.",
             results_seen, errors_seen, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
